// ----- hw/rtl/ip_address_text_parser_unit_defines.svh -----
// Assertion helpers used by the parser back end (ipp_back).
`ifndef IP_ADDRESS_TEXT_PARSER_UNIT_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define IPP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IPP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ipp_pkg.sv -----
package ipp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// One character after classification.
	typedef struct packed {
		logic [7:0] c;
		logic [7:0] lc;
		logic       is_hex;
		logic       is_dec;
		logic [3:0] hexv;
		logic       is_colon;
		logic       is_dot;
		logic       last;
		logic       empty;
	} cls_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] high;
		logic [63:0] low;
	} res_t;

endpackage

// ----- hw/rtl/ip_address_text_parser_unit.sv -----
// The last char of a string is first registered in the input queue; the parser then writes
// the string's result into the result queue, which drives the result ports.
// Throughput: one character per cycle; the parser holds only while two results
// wait unpopped.
// The 4-entry input queue and 2-entry result queue let each side stall on its own.
// Reset (arst_n low, asynchronous): both queues empty, parser at start of string.
module ip_address_text_parser_unit import ipp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	input  logic        empty_string,
	output logic        empty,
	input  logic        pop,
	output logic        addr_valid,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	logic cls_avail;
	cls_t cls_head;
	logic cls_take;

	ipp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.last_char    (last_char),
		.empty_string (empty_string),
		.cls_avail    (cls_avail),
		.cls_head     (cls_head),
		.cls_take     (cls_take)
	);

	ipp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls_avail  (cls_avail),
		.cls_head   (cls_head),
		.cls_take   (cls_take),
		.empty      (empty),
		.pop        (pop),
		.addr_valid (addr_valid),
		.addr_high  (addr_high),
		.addr_low   (addr_low)
	);

endmodule

// ----- hw/rtl/ipp_front.sv -----
module ipp_front import ipp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       empty_string,
	output logic       cls_avail,
	output cls_t       cls_head,
	input  logic       cls_take
);

	cls_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wptr_q;
	logic [QPTR_W-1:0]    rptr_q;
	logic [QPTR_W:0]      cnt_q;
	cls_t                 cls_in;
	logic                 wr_en;
	logic                 rd_en;

	always_comb begin
		cls_in          = '0;
		cls_in.c        = char_code;
		cls_in.lc       = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;
		cls_in.is_colon = (char_code == CH_COLON);
		cls_in.is_dot   = (char_code == CH_DOT);
		cls_in.last     = last_char;
		cls_in.empty    = empty_string;
		if (char_code >= "0" && char_code <= "9") begin
			cls_in.is_hex = 1'b1;
			cls_in.is_dec = 1'b1;
			cls_in.hexv   = 4'(char_code - "0");
		end else if (char_code >= "a" && char_code <= "f") begin
			cls_in.is_hex = 1'b1;
			cls_in.hexv   = 4'(char_code - "a" + 8'd10);
		end else if (char_code >= "A" && char_code <= "F") begin
			cls_in.is_hex = 1'b1;
			cls_in.hexv   = 4'(char_code - "A" + 8'd10);
		end
	end

	assign full      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign cls_avail = (cnt_q != '0);
	assign cls_head  = mem_q[rptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cls_take && cls_avail;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= cls_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + 1'b1;
			if (rd_en) rptr_q <= rptr_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- hw/rtl/ipp_back.sv -----
module ipp_back import ipp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cls_avail,
	input  cls_t        cls_head,
	output logic        cls_take,
	output logic        empty,
	input  logic        pop,
	output logic        addr_valid,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);
`include "ip_address_text_parser_unit_defines.svh"

	typedef enum logic [2:0] {
		HX_HEAD_START, HX_HEAD_DIGITS, HX_HEAD_COLON, HX_NEED_COLON,
		HX_TAIL_OPEN, HX_TAIL_DIGITS, HX_DONE, HX_FAIL
	} hx_t;

	typedef enum logic [2:0] {
		DC_PREFIX, DC_START, DC_DIGITS, DC_DONE, DC_FAIL
	} dc_t;

	typedef struct packed {
		logic [7:0][15:0] head;
		logic [7:0][15:0] tail;
		logic [3:0]       hc;
		logic [3:0]       tc;
		hx_t              hx;
		logic [15:0]      hacc;
		logic             gap;
		logic [3:0][7:0]  quad;
		logic [2:0]       qc;
		logic [7:0]       dacc;
		dc_t              dp;
		logic             dot;
		logic [3:0]       mpos;
		logic             mmiss;
		logic [2:0]       ppos;
		logic             started;
		logic             ended;
	} st_t;

	function automatic logic [7:0] unspec_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = "<";
			3'd1: r = "u";
			3'd2: r = "n";
			3'd3: r = "s";
			3'd4: r = "p";
			3'd5: r = "e";
			3'd6: r = "c";
			default: r = ">";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0, 3'd1, 3'd6: r = ":";
			default: r = "f";
		endcase
		return r;
	endfunction

	function automatic st_t feed(input st_t s, input cls_t k);
		st_t         n;
		logic [19:0] hsum;
		logic [11:0] dsum;
		logic [3:0]  hc1;
		logic [3:0]  tc1;
		logic [2:0]  qc1;
		n    = s;
		hsum = {s.hacc, k.hexv};
		dsum = 12'({s.dacc, 3'b000}) + 12'({s.dacc, 1'b0}) + 12'(k.hexv);
		hc1  = s.hc + 4'd1;
		tc1  = s.tc + 4'd1;
		qc1  = s.qc + 3'd1;
		if (!s.ended) begin
			if (k.c == CH_NUL) begin
				n.ended = 1'b1;
			end else begin
				n.started = 1'b1;
				if (!s.mmiss) begin
					if (s.mpos < 4'd8 && k.c == unspec_char(s.mpos[2:0])) n.mpos = s.mpos + 4'd1;
					else n.mmiss = 1'b1;
				end
				if (k.is_dot) n.dot = 1'b1;
			end
			unique case (s.hx)
				HX_HEAD_START, HX_HEAD_COLON: begin
					if (k.is_hex) begin
						n.hacc = 16'(k.hexv);
						n.hx   = HX_HEAD_DIGITS;
					end else if (k.is_colon) begin
						if (s.hx == HX_HEAD_START) begin
							n.hx = HX_NEED_COLON;
						end else begin
							n.gap = 1'b1;
							n.hx  = HX_TAIL_OPEN;
						end
					end else begin
						n.hx = HX_FAIL;
					end
				end
				HX_HEAD_DIGITS: begin
					if (k.is_hex) begin
						n.hacc = hsum[15:0];
						if (hsum[19:16] != '0) n.hx = HX_FAIL;
					end else begin
						n.head[s.hc[2:0]] = s.hacc;
						n.hc = hc1;
						if (k.is_colon) n.hx = (hc1 >= 4'd8) ? HX_NEED_COLON : HX_HEAD_COLON;
						else n.hx = HX_DONE;
					end
				end
				HX_NEED_COLON: begin
					if (k.is_colon) begin
						n.gap = 1'b1;
						n.hx  = HX_TAIL_OPEN;
					end else begin
						n.hx = HX_DONE;
					end
				end
				HX_TAIL_OPEN: begin
					if (k.is_hex) begin
						n.hacc = 16'(k.hexv);
						n.hx   = HX_TAIL_DIGITS;
					end else begin
						n.hx = HX_DONE;
					end
				end
				HX_TAIL_DIGITS: begin
					if (k.is_hex) begin
						n.hacc = hsum[15:0];
						if (hsum[19:16] != '0) n.hx = HX_DONE;
					end else begin
						n.tail[s.tc[2:0]] = s.hacc;
						n.tc = tc1;
						n.hx = (k.is_colon && tc1 < 4'd8) ? HX_TAIL_OPEN : HX_DONE;
					end
				end
				default: ;
			endcase
			unique case (s.dp)
				DC_PREFIX: begin
					if (s.ppos == 3'd0) begin
						if (k.is_colon) begin
							n.ppos = 3'd1;
						end else if (k.is_dec) begin
							n.dacc = 8'(k.hexv);
							n.dp   = DC_DIGITS;
						end else begin
							n.dp = DC_FAIL;
						end
					end else if (s.ppos < 3'd7 && k.lc == prefix_char(s.ppos)) begin
						n.ppos = s.ppos + 3'd1;
						if (s.ppos == 3'd6) n.dp = DC_START;
					end else begin
						n.dp = DC_FAIL;
					end
				end
				DC_START: begin
					if (k.is_dec) begin
						n.dacc = 8'(k.hexv);
						n.dp   = DC_DIGITS;
					end else begin
						n.dp = DC_FAIL;
					end
				end
				DC_DIGITS: begin
					if (k.is_dec) begin
						n.dacc = dsum[7:0];
						if (dsum > 12'd255) n.dp = DC_FAIL;
					end else begin
						n.quad[s.qc[1:0]] = s.dacc;
						n.qc = qc1;
						if (qc1 >= 3'd4) n.dp = DC_DONE;
						else if (k.is_dot) n.dp = DC_START;
						else n.dp = DC_FAIL;
					end
				end
				default: ;
			endcase
		end
		return n;
	endfunction

	st_t        st_q;
	st_t        st_a;
	st_t        st_b;
	res_t       res;
	res_t       omem_q [2];
	logic       owp_q;
	logic       orp_q;
	logic [1:0] ocnt_q;
	logic       opush;
	logic       opop;
	logic [4:0] jx;
	logic [15:0] g;
	logic [127:0] addr;

	localparam st_t ST_CLEAR = '{hx: HX_HEAD_START, dp: DC_PREFIX, default: '0};

	assign cls_take = cls_avail && (ocnt_q != 2'd2);
	assign opush    = cls_take && cls_head.last;
	assign opop     = pop && (ocnt_q != 2'd0);

	always_comb begin
		st_a = feed(st_q, cls_head);
		st_b = feed(st_a, '0);
		res  = '0;
		addr = '0;
		jx   = '0;
		g    = '0;
		if (cls_head.empty || !st_b.started) begin
			res.valid = 1'b0;
		end else if (!st_b.mmiss && st_b.mpos == 4'd8) begin
			res.valid = 1'b1;
		end else if (st_b.dot) begin
			if (st_b.dp == DC_DONE) begin
				res.valid = 1'b1;
				res.low   = {32'h0000_FFFF, st_b.quad[0], st_b.quad[1], st_b.quad[2], st_b.quad[3]};
			end
		end else if (st_b.hx != HX_FAIL) begin
			if (st_b.gap) res.valid = (5'(st_b.hc) + 5'(st_b.tc)) <= 5'd8;
			else res.valid = (st_b.hc == 4'd8);
			if (res.valid) begin
				for (int i = 0; i < 8; i++) begin
					jx = 5'(i) + 5'(st_b.tc);
					if (4'(i) < st_b.hc) g = st_b.head[i];
					else if (jx < 5'd8) g = '0;
					else g = st_b.tail[jx[2:0]];
					addr[127-16*i -: 16] = g;
				end
				res.high = addr[127:64];
				res.low  = addr[63:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opush) omem_q[owp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			// restart the parse after each result
			if (cls_take) st_q <= cls_head.last ? ST_CLEAR : st_a;
			if (opush) owp_q <= ~owp_q;
			if (opop) orp_q <= ~orp_q;
			if (opush && !opop) ocnt_q <= ocnt_q + 2'd1;
			else if (opop && !opush) ocnt_q <= ocnt_q - 2'd1;
		end
	end

	assign empty      = (ocnt_q == 2'd0);
	assign addr_valid = omem_q[orp_q].valid;
	assign addr_high  = omem_q[orp_q].high;
	assign addr_low   = omem_q[orp_q].low;

	`IPP_ASSERT_ALWAYS(a_ocnt_bound, ocnt_q <= 2'd2, "result queue overrun")
	`IPP_ASSERT_ALWAYS(a_grp_bound, st_q.hc <= 4'd8 && st_q.tc <= 4'd8, "group count overrun")
	`IPP_ASSERT_IMPLY(a_push_last, opush, cls_avail && cls_head.last, "result without last char")

endmodule
